>>> design/negabinary_rank_remap_defines.svh
// Assertion macros for the checker of the rank remap block.
`ifndef NEGABINARY_RANK_REMAP_DEFINES_SVH
`define NEGABINARY_RANK_REMAP_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define NRR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("nbrr assertion failed");

// Consequent in the cycle after the antecedent.
`define NRR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("nbrr assertion failed");

`endif

>>> design/nbrr_pkg.sv
package nbrr_pkg;

  localparam int RANK_W  = 19;
  localparam int COUNT_W = 20;
  // Internal code width: one digit more than the widest count needs.
  localparam int CODE_W  = 21;
  localparam int DIGIT_W = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CODE_W-1:0] ODD_DIGITS  = 21'h0AAAAA;
  localparam logic [CODE_W-1:0] EVEN_DIGITS = 21'h155555;

  localparam logic [COUNT_W-1:0] RESET_COUNT = 20'd2;

  // Register index, taken from paddr above the byte offset.
  localparam logic REG_RANK_COUNT = 1'b0;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [DIGIT_W-1:0] digits;
    logic [CODE_W-1:0]  mask;
    logic [CODE_W-1:0]  top_digit;
    logic               digits_ok;
  } cfg_t;

  typedef struct packed {
    logic [RANK_W-1:0] nega;
    logic [RANK_W-1:0] gray;
    logic [RANK_W-1:0] remap;
    logic              invalid;
  } result_t;

  // Smallest n with 2^n >= count; zero for counts of zero and one.
  function automatic logic [DIGIT_W-1:0] digit_count(logic [COUNT_W-1:0] count);
    logic [COUNT_W-1:0] m1;
    logic [DIGIT_W-1:0] n;
    m1 = count - COUNT_W'(1);
    n  = '0;
    for (int i = 0; i < COUNT_W; i++) begin
      if (m1[i]) begin
        n = DIGIT_W'(i + 1);
      end
    end
    if (count == '0) begin
      n = '0;
    end
    return n;
  endfunction

endpackage

>>> design/nbrr_cfg.sv
module nbrr_cfg #(
  parameter int MAX_DIGITS = 19
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nbrr_pkg::ADDR_W-1:0] paddr,
  input  logic [nbrr_pkg::DATA_W-1:0] pwdata,
  output logic [nbrr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output nbrr_pkg::cfg_t              cfg_o
);

  nbrr_pkg::cfg_t cfg_q, cfg_d, cfg_rst;
  logic           wr_en;

  // Derived fields are worked out once, at the write, so the datapath
  // sees only registered values.
  function automatic nbrr_pkg::cfg_t make_cfg(logic [nbrr_pkg::COUNT_W-1:0] count);
    nbrr_pkg::cfg_t c;
    c.count     = count;
    c.digits    = nbrr_pkg::digit_count(count);
    c.mask      = (nbrr_pkg::CODE_W'(1) << c.digits) - nbrr_pkg::CODE_W'(1);
    c.top_digit = c.mask ^ (c.mask >> 1);
    c.digits_ok = c.digits <= nbrr_pkg::DIGIT_W'(MAX_DIGITS);
    return c;
  endfunction

  assign wr_en   = psel && penable && pwrite && (paddr[2] == nbrr_pkg::REG_RANK_COUNT);
  assign cfg_rst = make_cfg(nbrr_pkg::RESET_COUNT);
  assign cfg_d   = wr_en ? make_cfg(pwdata[nbrr_pkg::COUNT_W-1:0]) : cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfg_rst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == nbrr_pkg::REG_RANK_COUNT)
                ? {{(nbrr_pkg::DATA_W - nbrr_pkg::COUNT_W){1'b0}}, cfg_q.count}
                : '0;
  assign cfg_o  = cfg_q;

endmodule

>>> design/nbrr_core.sv
module nbrr_core (
  input  logic [nbrr_pkg::RANK_W-1:0] rank_i,
  input  nbrr_pkg::cfg_t              cfg_i,
  output nbrr_pkg::result_t           res_o
);

  localparam int W = nbrr_pkg::CODE_W;

  logic signed [W-1:0] rank_s, count_s, cand_a, cand_b, lo, hi;
  logic        [W-1:0] code_a, code_b, code, gray, rev, remap;
  logic                fit_a, fit_b, rank_below, ok;

  always_comb begin
    rank_s  = signed'({2'b00, rank_i});
    count_s = signed'({1'b0, cfg_i.count});
    // Odd ranks try rank and rank - count, even ranks the negated pair.
    if (rank_i[0]) begin
      cand_a = rank_s;
      cand_b = rank_s - count_s;
    end else begin
      cand_a = -rank_s;
      cand_b = count_s - rank_s;
    end

    hi    = signed'(nbrr_pkg::EVEN_DIGITS & cfg_i.mask);
    lo    = -signed'(nbrr_pkg::ODD_DIGITS & cfg_i.mask);
    fit_a = (cand_a >= lo) && (cand_a <= hi);
    fit_b = (cand_b >= lo) && (cand_b <= hi);

    code_a = fit_a ? ((nbrr_pkg::ODD_DIGITS + unsigned'(cand_a)) ^ nbrr_pkg::ODD_DIGITS) : '0;
    code_b = fit_b ? ((nbrr_pkg::ODD_DIGITS + unsigned'(cand_b)) ^ nbrr_pkg::ODD_DIGITS) : '0;

    rank_below = {1'b0, rank_i} < cfg_i.count;
    ok         = rank_below && cfg_i.digits_ok && (fit_a || fit_b);

    // When both fit, the first code wins only with its top digit set.
    if (fit_a && !fit_b) begin
      code = code_a;
    end else if (!fit_a && fit_b) begin
      code = code_b;
    end else if ((code_a & cfg_i.top_digit) != '0) begin
      code = code_a;
    end else begin
      code = code_b;
    end
    if (!ok) begin
      code = '0;
    end

    gray = code ^ (code >> 1);
    for (int i = 0; i < W; i++) begin
      rev[i] = gray[W-1-i];
    end
    remap = rev >> (nbrr_pkg::DIGIT_W'(W) - cfg_i.digits);

    res_o.nega    = code[nbrr_pkg::RANK_W-1:0];
    res_o.gray    = gray[nbrr_pkg::RANK_W-1:0];
    res_o.remap   = remap[nbrr_pkg::RANK_W-1:0];
    res_o.invalid = !ok;
  end

endmodule

>>> design/negabinary_rank_remap.sv
// Negabinary rank remapper.
// The input channel (in_valid_i / in_ready_o) carries one rank per item; the
// output channel (out_valid_o / out_ready_i) returns one item per rank with
// the negabinary code, its Gray code, the bit-reversed remapped rank and an
// invalid flag. The rank count is written over the APB port at address 0;
// it may only change while no item is in flight.
// On acceptance the input register takes the rank; the remap logic then loads
// the result register once it is free, which raises out_valid_o.
// Throughput is one item per cycle while out_ready_i is high, set by the
// combinational path between the input register and the result register.
// Reset clears both valid flags and sets the rank count to 2.
// When the receiver stalls, the result register holds its item and the
// input register keeps one more; in_ready_o falls only when both are full.
// in_ready_o is always high while out_ready_i is high.
module negabinary_rank_remap #(
  parameter int MAX_DIGITS = 19
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nbrr_pkg::ADDR_W-1:0] paddr,
  input  logic [nbrr_pkg::DATA_W-1:0] pwdata,
  output logic [nbrr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [nbrr_pkg::RANK_W-1:0] rank_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [nbrr_pkg::RANK_W-1:0] nega_code_o,
  output logic [nbrr_pkg::RANK_W-1:0] gray_code_o,
  output logic [nbrr_pkg::RANK_W-1:0] remapped_rank_o,
  output logic                        invalid_o
);

  nbrr_pkg::cfg_t              cfg;
  nbrr_pkg::result_t           res, res_q;
  logic [nbrr_pkg::RANK_W-1:0] rank_q;
  logic                        in_v_q, in_v_d, out_v_q, out_v_d;
  logic                        out_free, advance;

  nbrr_cfg #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  nbrr_core u_core (
    .rank_i(rank_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  assign out_free   = !out_v_q || out_ready_i;
  assign advance    = in_v_q && out_free;
  assign in_ready_o = !in_v_q || out_free;

  assign in_v_d  = (in_valid_i && in_ready_o) || (in_v_q && !advance);
  assign out_v_d = advance || (out_v_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rank_q <= rank_in_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_v_q;
  assign nega_code_o     = res_q.nega;
  assign gray_code_o     = res_q.gray;
  assign remapped_rank_o = res_q.remap;
  assign invalid_o       = res_q.invalid;

endmodule

>>> design/nbrr_checker.sv
`include "negabinary_rank_remap_defines.svh"

module nbrr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [nbrr_pkg::RANK_W-1:0] nega_code_o,
  input logic [nbrr_pkg::RANK_W-1:0] gray_code_o,
  input logic [nbrr_pkg::RANK_W-1:0] remapped_rank_o,
  input logic                        invalid_o
);

  // A stalled result item keeps its valid, its negabinary code, its remapped rank and its invalid flag.
  `NRR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(nega_code_o) && $stable(remapped_rank_o) && $stable(invalid_o))

  // An invalid item carries all-zero codes.
  `NRR_ASSERT_SAME(a_invalid_zero, clk_i, rst_ni, out_valid_o && invalid_o, nega_code_o == '0 && gray_code_o == '0 && remapped_rank_o == '0)

  // The Gray code follows the negabinary code on the bits both show.
  `NRR_ASSERT_SAME(a_gray_match, clk_i, rst_ni, out_valid_o, gray_code_o[nbrr_pkg::RANK_W-2:0] == (nega_code_o[nbrr_pkg::RANK_W-2:0] ^ nega_code_o[nbrr_pkg::RANK_W-1:1]))

  // A draining receiver never holds off the sender.
  `NRR_ASSERT_SAME(a_no_bubble, clk_i, rst_ni, out_ready_i, in_ready_o)

endmodule

bind negabinary_rank_remap nbrr_checker u_nbrr_checker (.*);
